/* hdl/mcc_pkg.sv */
// shared types, constants and the microcode table of the minimum coin change block
// depends on nothing; imported by the sequencer, the datapath and the top level
package mcc_pkg;

  localparam int NUM_DENOMS     = 5;
  localparam int DENOM_W        = 8;
  localparam int AMOUNT_W       = 8;
  localparam int COUNT_W        = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_AMOUNT_W   = 12;
  localparam int DEF_MAX_AMOUNT = 255;
  localparam int AMOUNT_TOP     = (1 << AMOUNT_W) - 1;
  localparam int DENOM_IDX_W    = $clog2(NUM_DENOMS);

  localparam logic [DENOM_W-1:0] DENOM_RESET [NUM_DENOMS] =
    '{8'd1, 8'd5, 8'd10, 8'd20, 8'd50};

  // step codes of the microprogram
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE      = 3'd0;
  localparam step_t STEP_CHECK     = 3'd1;
  localparam step_t STEP_ISSUE     = 3'd2;
  localparam step_t STEP_READ_EVAL = 3'd3;
  localparam step_t STEP_EVAL_LAST = 3'd4;
  localparam step_t STEP_RESULT_RD = 3'd5;
  localparam step_t STEP_FINISH    = 3'd6;

  typedef enum logic [2:0] {
    COND_NEVER       = 3'd0,
    COND_NO_ITEM     = 3'd1,
    COND_DONE        = 3'd2,
    COND_MORE_DENOMS = 3'd3,
    COND_OUT_BUSY    = 3'd4
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  step_s;
    logic  issue;
    logic  eval;
    logic  write_s;
    logic  read_result;
    logic  load_out;
    cond_t cond;
    step_t target;
    step_t next_step;
  } ctrl_t;

  typedef struct packed {
    logic done;
    logic more_denoms;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic               reach;
    logic [COUNT_W-1:0] best;
  } entry_t;

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w           = '0;
    w.cond      = COND_NEVER;
    w.target    = STEP_IDLE;
    w.next_step = STEP_IDLE;
    unique case (pc)
      STEP_IDLE: begin
        w.accept    = 1'b1;
        w.cond      = COND_NO_ITEM;
        w.target    = STEP_IDLE;
        w.next_step = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.step_s    = 1'b1;
        w.cond      = COND_DONE;
        w.target    = STEP_RESULT_RD;
        w.next_step = STEP_ISSUE;
      end
      STEP_ISSUE: begin
        w.issue     = 1'b1;
        w.next_step = STEP_READ_EVAL;
      end
      STEP_READ_EVAL: begin
        w.issue     = 1'b1;
        w.eval      = 1'b1;
        w.cond      = COND_MORE_DENOMS;
        w.target    = STEP_READ_EVAL;
        w.next_step = STEP_EVAL_LAST;
      end
      STEP_EVAL_LAST: begin
        w.eval      = 1'b1;
        w.write_s   = 1'b1;
        w.next_step = STEP_CHECK;
      end
      STEP_RESULT_RD: begin
        w.read_result = 1'b1;
        w.next_step   = STEP_FINISH;
      end
      STEP_FINISH: begin
        w.load_out  = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.target    = STEP_FINISH;
        w.next_step = STEP_IDLE;
      end
      default: begin
        w.next_step = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/mcc_useq.sv */
// microcode sequencer: step counter, control word table and jump logic
// depends on mcc_pkg
module mcc_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  mcc_pkg::status_t status,
  output mcc_pkg::ctrl_t   ctrl
);
  import mcc_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  taken;

  assign ctrl = ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:       taken = 1'b0;
      COND_NO_ITEM:     taken = !item_valid;
      COND_DONE:        taken = status.done;
      COND_MORE_DENOMS: taken = status.more_denoms;
      COND_OUT_BUSY:    taken = status.out_busy;
      default:          taken = 1'b0;
    endcase
    pc_next = taken ? ctrl.target : ctrl.next_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hdl/mcc_dpath.sv */
// datapath: denomination registers, table of best counts per sum, compare-add unit
// and the output register; driven by control words from mcc_useq, depends on mcc_pkg
module mcc_dpath #(
  parameter int MaxAmount = mcc_pkg::DEF_MAX_AMOUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcc_pkg::DENOM_W-1:0]    cfg_data,
  input  logic                           take_item,
  input  logic [mcc_pkg::AMOUNT_W-1:0]   amount,
  input  mcc_pkg::ctrl_t                 ctrl,
  output mcc_pkg::status_t               status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mcc_pkg::COUNT_W-1:0]    fewest_coins,
  output logic                           found
);
  import mcc_pkg::*;

  localparam int Depth = ((MaxAmount < AMOUNT_TOP) ? MaxAmount : AMOUNT_TOP) + 1;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DENOM_W-1:0]     denom [NUM_DENOMS];
  entry_t                 mem [Depth];
  entry_t                 mem_q;
  logic                   rd_ok;
  logic                   rd_ok_next;
  logic [IdxW-1:0]        rd_addr;

  logic [AMOUNT_W-1:0]    amt;
  logic                   in_range;
  logic [AMOUNT_W-1:0]    s;
  logic [DENOM_IDX_W-1:0] k;
  entry_t                 cur;
  entry_t                 cur_next;

  logic [DENOM_W-1:0]     denom_sel;
  logic                   issue_ok;
  logic [AMOUNT_W-1:0]    addr_diff;
  logic [COUNT_W-1:0]     cand;
  logic                   upd;
  logic                   res_found;
  logic                   out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        denom[i] <= DENOM_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_DENOMS))) begin
      denom[cfg_index] <= cfg_data;
    end
  end

  // coin of zero value or above the current sum takes no part
  assign denom_sel = denom[k];
  assign issue_ok  = (denom_sel != '0) && (denom_sel <= s);
  assign addr_diff = s - denom_sel;

  assign rd_addr    = ctrl.read_result ? amt[IdxW-1:0] : addr_diff[IdxW-1:0];
  assign rd_ok_next = ctrl.read_result ? in_range : issue_ok;

  assign cand     = mem_q.best + COUNT_W'(1);
  assign upd      = rd_ok && mem_q.reach && (!cur.reach || (cand < cur.best));
  assign cur_next = upd ? entry_t'{reach: 1'b1, best: cand} : cur;

  // entries above the current sum are never read, so the table needs no clearing
  always_ff @(posedge clk) begin
    if (take_item) begin
      mem[IdxW'(0)] <= '{reach: 1'b1, best: '0};
    end else if (ctrl.write_s) begin
      mem[s[IdxW-1:0]] <= cur_next;
    end
    if (ctrl.issue || ctrl.read_result) begin
      mem_q <= mem[rd_addr];
      rd_ok <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      amt      <= amount;
      in_range <= {{(MAX_AMOUNT_W - AMOUNT_W){1'b0}}, amount} <= MAX_AMOUNT_W'(MaxAmount);
      s        <= '0;
    end
    if (ctrl.step_s) begin
      s   <= s + AMOUNT_W'(1);
      k   <= '0;
      cur <= '0;
    end
    if (ctrl.issue) begin
      k <= k + DENOM_IDX_W'(1);
    end
    if (ctrl.eval) begin
      cur <= cur_next;
    end
  end

  assign status.done        = (s == amt) || !in_range;
  assign status.more_denoms = (k != DENOM_IDX_W'(NUM_DENOMS - 1));
  assign status.out_busy    = out_busy;

  assign out_busy  = out_valid && out_stall;
  assign res_found = rd_ok && mem_q.reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out && !out_busy) begin
      found        <= res_found;
      fewest_coins <= res_found ? mem_q.best : '0;
    end
  end

endmodule

/* hdl/min_coin_change_five_core.sv */
// an item is solved sum by sum, then its result is read and loaded out; one out of range
// skips the sums. A new item is taken only once the last result is loaded. Each sum makes
// one table read per coin kind through the single read port
// reset: synchronous, active high; denominations return to 1, 5, 10, 20, 50 and the
// sequencer to its idle step; the count table needs no clearing
module min_coin_change_five_core #(
  parameter int MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcc_pkg::DENOM_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcc_pkg::AMOUNT_W-1:0]  amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcc_pkg::COUNT_W-1:0]   fewest_coins,
  output logic                          found
);
  import mcc_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    take_item;

  assign in_stall  = !ctrl.accept;
  assign take_item = in_valid && ctrl.accept;

  mcc_useq u_useq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .status     (status),
    .ctrl       (ctrl)
  );

  mcc_dpath #(
    .MaxAmount (MAX_AMOUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take_item    (take_item),
    .amount       (amount),
    .ctrl         (ctrl),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fewest_coins (fewest_coins),
    .found        (found)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the input side closed while it is solved
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an item was accepted");

  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (fewest_coins == '0))
    else $error("nonzero count without a combination");

  // a new result only appears at the end of a solve
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");
`endif

endmodule
